// ===== sv/b36t_pkg.sv =====
// Shared constants, types and helper functions for the base-36 text converter.
`timescale 1ns / 1ps

package b36t_pkg;

    // Input word width and conversion geometry
    localparam int VALUE_WIDTH    = 32;
    localparam int DIGIT_W        = 6;
    localparam int HALF_RADIX     = 18;
    localparam int BITS_PER_CYCLE = 4;
    localparam int STEPS          = (VALUE_WIDTH + BITS_PER_CYCLE - 1) / BITS_PER_CYCLE;
    localparam int MAG_PAD_W      = STEPS * BITS_PER_CYCLE;
    localparam int STEP_CNT_W     = $clog2(STEPS);

    // Queue between classifier and converter
    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    // ASCII codes
    localparam logic [6:0] CHAR_MINUS = 7'h2d;
    localparam logic [6:0] CHAR_ZERO  = 7'h30;
    localparam logic [6:0] CHAR_A     = 7'h61;
    localparam logic [6:0] TEN        = 7'd10;

    // Count base-36 digits needed for the largest magnitude, 2^(VALUE_WIDTH-1)
    function automatic int calc_digits();
        logic [127:0] pw;
        logic [127:0] lim;
        int           n;
        pw  = 128'd1;
        lim = 128'd1 << (VALUE_WIDTH - 1);
        n   = 0;
        while (pw <= lim) begin
            pw = pw * 128'd36;
            n  = n + 1;
        end
        return n;
    endfunction

    localparam int NUM_DIGITS  = calc_digits();
    localparam int DIGIT_IDX_W = $clog2(NUM_DIGITS);

    typedef logic [DIGIT_W-1:0] t_digit;

    // Classified item: sign and unsigned magnitude
    typedef struct packed {
        logic                   neg;
        logic [VALUE_WIDTH-1:0] mag;
    } t_item;

    // Converted number: sign and digits, least significant digit at index 0
    typedef struct packed {
        logic                        neg;
        t_digit [NUM_DIGITS-1:0]     digits;
    } t_conv;

    // Map a digit value 0..35 to its ASCII character
    function automatic logic [6:0] digit_char(t_digit d);
        if (7'(d) < TEN) begin
            return CHAR_ZERO + 7'(d);
        end
        return CHAR_A + 7'(d) - TEN;
    endfunction

endpackage

// ===== sv/b36t_front.sv =====
// Front end: accepts input integers and splits them into sign and magnitude.
`timescale 1ns / 1ps

module b36t_front (
    input  logic                            i_valid,
    input  logic [b36t_pkg::VALUE_WIDTH-1:0] i_value,
    input  logic                            i_fifo_full,
    output logic                            o_stall,
    output logic                            o_push,
    output b36t_pkg::t_item                 o_item
);

    logic neg;

    // Hold off the source while the queue is full
    assign o_stall = i_fifo_full;
    assign o_push  = i_valid && !i_fifo_full;

    // Take the magnitude; the most negative value wraps to 2^(W-1) unsigned
    assign neg        = i_value[b36t_pkg::VALUE_WIDTH-1];
    assign o_item.neg = neg;
    assign o_item.mag = neg ? (~i_value + b36t_pkg::VALUE_WIDTH'(1)) : i_value;

endmodule

// ===== sv/b36t_fifo.sv =====
// Short queue of classified items between the front end and the converter.
`timescale 1ns / 1ps

module b36t_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  b36t_pkg::t_item i_item,
    input  logic            i_pop,
    output logic            o_valid,
    output logic            o_full,
    output b36t_pkg::t_item o_item
);

    b36t_pkg::t_item                     r_mem [b36t_pkg::FIFO_DEPTH];
    logic [b36t_pkg::FIFO_AW-1:0]        r_wr_ptr;
    logic [b36t_pkg::FIFO_AW-1:0]        r_rd_ptr;
    logic [b36t_pkg::FIFO_CNT_W-1:0]     r_count;

    assign o_valid = (r_count != '0);
    assign o_full  = (r_count == b36t_pkg::FIFO_CNT_W'(b36t_pkg::FIFO_DEPTH));
    assign o_item  = r_mem[r_rd_ptr];

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + b36t_pkg::FIFO_AW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + b36t_pkg::FIFO_AW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + b36t_pkg::FIFO_CNT_W'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - b36t_pkg::FIFO_CNT_W'(1);
            end
        end
    end

    // Store entries
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

// ===== sv/b36t_conv.sv =====
// Converter: shifts the magnitude into base-36 digit registers, four bits a cycle.
`timescale 1ns / 1ps

module b36t_conv (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_fifo_valid,
    input  b36t_pkg::t_item i_item,
    output logic            o_pop,
    output logic            o_done,
    output b36t_pkg::t_conv o_result,
    input  logic            i_ready
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DONE
    } t_state;

    t_state                                              r_state;
    logic [b36t_pkg::MAG_PAD_W-1:0]                      r_mag;
    logic                                                r_neg;
    b36t_pkg::t_digit [b36t_pkg::NUM_DIGITS-1:0]         r_digits;
    logic [b36t_pkg::STEP_CNT_W-1:0]                     r_cnt;
    b36t_pkg::t_digit [b36t_pkg::NUM_DIGITS-1:0]         n_digits;
    b36t_pkg::t_digit [b36t_pkg::NUM_DIGITS-1:0]         d_cur;
    b36t_pkg::t_digit [b36t_pkg::NUM_DIGITS-1:0]         d_base;
    logic [b36t_pkg::NUM_DIGITS-1:0]                     carry;
    logic                                                load;
    logic                                                last_step;

    assign load      = i_fifo_valid &&
                       ((r_state == S_IDLE) || ((r_state == S_DONE) && i_ready));
    assign last_step = (r_cnt == b36t_pkg::STEP_CNT_W'(b36t_pkg::STEPS - 1));
    assign o_pop     = load;
    assign o_done    = (r_state == S_DONE);
    assign o_result.neg    = r_neg;
    assign o_result.digits = r_digits;

    // Double every digit and add the next magnitude bit; a digit of 18 or more
    // wraps by 36 and carries into the next digit
    always_comb begin
        d_cur  = r_digits;
        d_base = r_digits;
        carry  = '0;
        for (int s = 0; s < b36t_pkg::BITS_PER_CYCLE; s++) begin
            for (int i = 0; i < b36t_pkg::NUM_DIGITS; i++) begin
                if (i == 0) begin
                    carry[i] = r_mag[b36t_pkg::MAG_PAD_W-1-s];
                end else begin
                    carry[i] = (d_cur[i-1] >= b36t_pkg::DIGIT_W'(b36t_pkg::HALF_RADIX));
                end
                if (d_cur[i] >= b36t_pkg::DIGIT_W'(b36t_pkg::HALF_RADIX)) begin
                    d_base[i] = d_cur[i] - b36t_pkg::DIGIT_W'(b36t_pkg::HALF_RADIX);
                end else begin
                    d_base[i] = d_cur[i];
                end
            end
            for (int i = 0; i < b36t_pkg::NUM_DIGITS; i++) begin
                d_cur[i] = {d_base[i][b36t_pkg::DIGIT_W-2:0], carry[i]};
            end
        end
        n_digits = d_cur;
    end

    // Sequence load, conversion steps and handoff
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (load) begin
                        r_state <= S_RUN;
                    end
                end
                S_RUN: begin
                    if (last_step) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (i_ready) begin
                        r_state <= load ? S_RUN : S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
            if (load) begin
                r_mag    <= b36t_pkg::MAG_PAD_W'(i_item.mag);
                r_neg    <= i_item.neg;
                r_digits <= '0;
                r_cnt    <= '0;
            end else if (r_state == S_RUN) begin
                r_mag    <= r_mag << b36t_pkg::BITS_PER_CYCLE;
                r_digits <= n_digits;
                r_cnt    <= r_cnt + b36t_pkg::STEP_CNT_W'(1);
            end
        end
    end

endmodule

// ===== sv/b36t_emit.sv =====
// Back end: drops leading zeros and sends sign and digit characters one per transfer.
`timescale 1ns / 1ps

module b36t_emit (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_done,
    input  b36t_pkg::t_conv i_result,
    output logic            o_ready,
    output logic            o_valid,
    output logic [6:0]      o_char_code,
    output logic            o_last_char,
    input  logic            i_stall
);

    b36t_pkg::t_digit [b36t_pkg::NUM_DIGITS-1:0] r_digits;
    logic [b36t_pkg::DIGIT_IDX_W-1:0]            r_idx;
    logic                                        r_sign;
    logic                                        r_busy;
    logic                                        r_out_valid;
    logic [6:0]                                  r_char;
    logic                                        r_last;
    logic [b36t_pkg::DIGIT_IDX_W-1:0]            top;
    logic                                        load;
    logic                                        advance;

    assign o_ready     = !r_busy;
    assign load        = i_done && !r_busy;
    assign advance     = !r_out_valid || !i_stall;
    assign o_valid     = r_out_valid;
    assign o_char_code = r_char;
    assign o_last_char = r_last;

    // Find the most significant nonzero digit; zero keeps the units digit
    always_comb begin
        top = '0;
        for (int i = 0; i < b36t_pkg::NUM_DIGITS; i++) begin
            if (i_result.digits[i] != '0) begin
                top = b36t_pkg::DIGIT_IDX_W'(i);
            end
        end
    end

    // Load a converted number, then move one character a cycle out unless stalled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_busy   <= 1'b1;
                r_digits <= i_result.digits;
                r_idx    <= top;
                r_sign   <= i_result.neg;
            end
            if (advance) begin
                if (r_busy) begin
                    r_out_valid <= 1'b1;
                    if (r_sign) begin
                        r_char <= b36t_pkg::CHAR_MINUS;
                        r_last <= 1'b0;
                        r_sign <= 1'b0;
                    end else begin
                        r_char <= b36t_pkg::digit_char(r_digits[r_idx]);
                        r_last <= (r_idx == '0);
                        if (r_idx == '0) begin
                            r_busy <= 1'b0;
                        end else begin
                            r_idx <= r_idx - b36t_pkg::DIGIT_IDX_W'(1);
                        end
                    end
                end else begin
                    r_out_valid <= 1'b0;
                end
            end
        end
    end

endmodule

// ===== sv/integer_to_base36_text_core.sv =====
// Top level: signed integer to base-36 ASCII character stream.
//
//  Channel | Direction | Handshake          | Payload
//  --------+-----------+--------------------+-------------------------------
//  input   | in        | i_valid / o_stall  | i_value (32-bit signed)
//  output  | out       | o_valid / i_stall  | o_char_code (7b), o_last_char
//
//  Conversion shifts the 32 magnitude bits in 4 per cycle, and a new number
//  starts only once the last result is handed off; a number leaves as 1
//  to 7 characters, one per cycle while the output is not stalled,
//  overlapped with the next conversion. Reset is synchronous, active low,
//  and empties every stage. A stall on the output holds the current
//  character; the two-entry queue keeps taking input until it fills.
`timescale 1ns / 1ps

module integer_to_base36_text_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    input  logic [b36t_pkg::VALUE_WIDTH-1:0] i_value,
    output logic                             o_stall,
    output logic                             o_valid,
    output logic [6:0]                       o_char_code,
    output logic                             o_last_char,
    input  logic                             i_stall
);

    b36t_pkg::t_item push_item;
    b36t_pkg::t_item head_item;
    b36t_pkg::t_conv conv_result;
    logic            push;
    logic            pop;
    logic            fifo_valid;
    logic            fifo_full;
    logic            conv_done;
    logic            emit_ready;

    // Classify incoming numbers
    b36t_front u_front (
        .i_valid     (i_valid),
        .i_value     (i_value),
        .i_fifo_full (fifo_full),
        .o_stall     (o_stall),
        .o_push      (push),
        .o_item      (push_item)
    );

    // Decouple front end from conversion
    b36t_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .i_pop   (pop),
        .o_valid (fifo_valid),
        .o_full  (fifo_full),
        .o_item  (head_item)
    );

    // Generate base-36 digits
    b36t_conv u_conv (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fifo_valid (fifo_valid),
        .i_item       (head_item),
        .o_pop        (pop),
        .o_done       (conv_done),
        .o_result     (conv_result),
        .i_ready      (emit_ready)
    );

    // Stream characters out
    b36t_emit u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_done      (conv_done),
        .i_result    (conv_result),
        .o_ready     (emit_ready),
        .o_valid     (o_valid),
        .o_char_code (o_char_code),
        .o_last_char (o_last_char),
        .i_stall     (i_stall)
    );

endmodule

// ===== test/tb_top.sv =====
// Self-checking testbench for the base-36 text converter: predicted text vs. streamed characters.
`timescale 1ns / 1ps

module tb_top;

    localparam int W             = b36t_pkg::VALUE_WIDTH;
    localparam int RANDOM_ITEMS  = 250;
    localparam int QUIET_ITEMS   = 40;
    localparam int DRAIN_CYCLES  = 24;
    localparam int MAX_REPORTS   = 100;
    localparam logic [W-1:0] RADIX = 36;
    localparam logic [W-1:0] DECIMAL_DIGITS = 10;

    // Boundary values: zero, sign and range extremes, digit-count edges
    localparam logic [W-1:0] DIRECTED_VALUES [23] = '{
        32'd0, 32'd1, -32'sd1, 32'd9, 32'd10, 32'd35, 32'd36, -32'sd10,
        -32'sd35, -32'sd36, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001,
        32'd1295, 32'd1296, 32'd46655, 32'd46656, 32'd1679615, 32'd1679616,
        32'd60466175, 32'd60466176, 32'h5555_5555, 32'hAAAA_AAAA
    };

    typedef struct {
        logic [6:0] char_code;
        logic       last_char;
    } t_text_char;

    // Expected character stream and its checks
    class text_scoreboard;
        t_text_char expected_chars[$];
        int         error_count;
        int         values_seen;
        int         chars_checked;

        function new();
            error_count   = 0;
            values_seen   = 0;
            chars_checked = 0;
        endfunction

        function int pending();
            return expected_chars.size();
        endfunction

        task report_mismatch(input string msg);
            error_count++;
            if (error_count <= MAX_REPORTS) begin
                $display("MISMATCH @%0t: %s", $time, msg);
            end
        endtask

        // Predict the text of one accepted value, sign first, top digit first
        function void note_value(input logic [W-1:0] value);
            logic [W-1:0] magnitude;
            logic [W-1:0] remainder;
            logic [6:0]   digit_chars[$];
            t_text_char   ch;
            values_seen++;
            magnitude = value[W-1] ? (~value + 1'b1) : value;
            if (magnitude == '0) begin
                ch = '{b36t_pkg::CHAR_ZERO, 1'b1};
                expected_chars.push_back(ch);
                return;
            end
            while (magnitude != '0) begin
                remainder = magnitude % RADIX;
                if (remainder < DECIMAL_DIGITS) begin
                    digit_chars.push_front(b36t_pkg::CHAR_ZERO + 7'(remainder));
                end else begin
                    digit_chars.push_front(b36t_pkg::CHAR_A + 7'(remainder - DECIMAL_DIGITS));
                end
                magnitude = magnitude / RADIX;
            end
            if (value[W-1]) begin
                ch = '{b36t_pkg::CHAR_MINUS, 1'b0};
                expected_chars.push_back(ch);
            end
            foreach (digit_chars[i]) begin
                ch = '{digit_chars[i], (i == digit_chars.size() - 1)};
                expected_chars.push_back(ch);
            end
        endfunction

        // Compare one output transfer with the oldest expected character
        task check_char(input logic [6:0] char_code, input logic last_char);
            t_text_char want;
            if (expected_chars.size() == 0) begin
                report_mismatch($sformatf("unexpected char 0x%02h last=%0b",
                                          char_code, last_char));
                return;
            end
            want = expected_chars.pop_front();
            chars_checked++;
            if (char_code !== want.char_code) begin
                report_mismatch($sformatf("char 0x%02h, expected 0x%02h",
                                          char_code, want.char_code));
            end
            if (last_char !== want.last_char) begin
                report_mismatch($sformatf("last_char %0b, expected %0b on char 0x%02h",
                                          last_char, want.last_char, want.char_code));
            end
        endtask
    endclass

    logic         i_clk   = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_valid = 1'b0;
    logic [W-1:0] i_value = '0;
    logic         i_stall = 1'b0;
    logic         o_stall;
    logic         o_valid;
    logic [6:0]   o_char_code;
    logic         o_last_char;

    bit             quiet_phase = 1'b0;
    int             feed_count  = 0;
    text_scoreboard board       = new();

    integer_to_base36_text_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_value     (i_value),
        .o_stall     (o_stall),
        .o_valid     (o_valid),
        .o_char_code (o_char_code),
        .o_last_char (o_last_char),
        .i_stall     (i_stall)
    );

    always #5 i_clk = ~i_clk;

    // Offer one value, after an optional idle burst; return once it is transferred
    task automatic feed_value(input logic [W-1:0] value);
        if (!quiet_phase && (feed_count / 16) % 3 != 2 && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            i_value <= $urandom();
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_value <= value;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        board.note_value(value);
        feed_count++;
    endtask

    // Output side: check each transfer, stall in random bursts
    initial begin : char_sink
        int stall_left;
        int cycle_count;
        stall_left  = 0;
        cycle_count = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && !i_stall) begin
                board.check_char(o_char_code, o_last_char);
            end
            if (stall_left > 0) begin
                stall_left--;
            end else if (!quiet_phase && (cycle_count / 150) % 3 != 2 &&
                         $urandom_range(0, 3) == 0) begin
                stall_left = $urandom_range(1, 12);
            end
            i_stall <= (stall_left > 0);
            cycle_count++;
        end
    end

    // Input side: directed values, then a random mix, then drain
    initial begin : value_source
        logic [W-1:0] power;
        logic [W-1:0] value;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (DIRECTED_VALUES[i]) begin
            feed_value(DIRECTED_VALUES[i]);
        end

        for (int item = 0; item < RANDOM_ITEMS; item++) begin
            if (item >= RANDOM_ITEMS - QUIET_ITEMS) begin
                quiet_phase = 1'b1;
            end
            case ($urandom_range(0, 5))
                0: value = $urandom();
                1: begin
                    value = $urandom_range(0, 100);
                    if ($urandom_range(0, 1)) value = -value;
                end
                2: begin
                    // land next to a power of the radix, where digit count changes
                    power = 1;
                    repeat ($urandom_range(1, 6)) power = power * RADIX;
                    value = power + $urandom_range(0, 2) - 1;
                    if ($urandom_range(0, 1)) value = -value;
                end
                3: begin
                    case ($urandom_range(0, 3))
                        0: value = '0;
                        1: value = {1'b1, {(W-1){1'b0}}};
                        2: value = {1'b0, {(W-1){1'b1}}};
                        default: value = '1;
                    endcase
                end
                4: value = W'(1) << $urandom_range(0, W - 1);
                default: value = $urandom() >> $urandom_range(0, W - 1);
            endcase
            feed_value(value);
        end
        i_valid <= 1'b0;

        while (board.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Converted %0d numbers and checked %0d characters,", board.values_seen,
                 board.chars_checked);
        $display("including zero, both range extremes, radix-power edges and random stalls.");
        if (board.error_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // Guard against a hung handshake
    initial begin : watchdog
        #(5_000_000);
        $display("TIMEOUT: %0d characters still expected", board.pending());
        $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== files.f =====
sv/b36t_pkg.sv
sv/b36t_front.sv
sv/b36t_fifo.sv
sv/b36t_conv.sv
sv/b36t_emit.sv
sv/integer_to_base36_text_core.sv
test/tb_top.sv
